// File: hdl/ilp_pkg.sv
package ilp_pkg;

  // accumulator width (32 to 64); the result port is always 64 bits
  localparam int VALUE_WIDTH = 64;
  localparam int OUT_VALUE_W = 64;

  // ascii codes used by the scanner
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_UP_L  = 8'h4c;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] UPPER_MASK = 8'h5f;

  // radix codes on the result port
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  // suffix kinds on the result port
  localparam logic [2:0] SFX_NONE = 3'd0;
  localparam logic [2:0] SFX_U    = 3'd1;
  localparam logic [2:0] SFX_L    = 3'd2;
  localparam logic [2:0] SFX_UL   = 3'd3;
  localparam logic [2:0] SFX_LL   = 3'd4;
  localparam logic [2:0] SFX_ULL  = 3'd5;

  // suffix buffer depth and saturating count limit
  localparam logic [2:0] SFX_DEPTH = 3'd3;
  localparam logic [2:0] SFX_SAT   = 3'd4;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SUFFIX = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  function automatic logic is_u(input logic [7:0] c);
    return (c == CH_LO_U) || (c == CH_UP_U);
  endfunction

  function automatic logic is_l(input logic [7:0] c);
    return (c == CH_LO_L) || (c == CH_UP_L);
  endfunction

  function automatic logic is_ll_pair(input logic [7:0] a, input logic [7:0] b);
    return ((a == CH_LO_L) && (b == CH_LO_L)) || ((a == CH_UP_L) && (b == CH_UP_L));
  endfunction

endpackage

// File: hdl/integer_literal_parser_unit.sv
// channel | ports                                      | direction
// in      | in_valid, in_stall, in_ch, in_last          | token characters, one per item
// out     | out_valid, out_stall, out_value, out_radix,  | one item per token,
//         | out_suffix_kind, out_overflow,              | on the character marked last
//         | out_bad_octal_digit, out_trailing_junk      |
//
// one character per cycle while the input register does not stall: an item waits in the
// input register, where its shift-add and suffix match update the token state and, on
// the last character, load the result register, which drives out_valid.
// the accumulator loop (shift-add by 8, 10 or 16 plus overflow check) sets the pace.
// rst_n is synchronous, active low; it clears all token state and both valid bits.
// out_stall holds the result register; the input register then stalls only when it
// holds a last character that cannot be written.
module integer_literal_parser_unit
  import ilp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_ch,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_VALUE_W-1:0] out_value,
  output logic [4:0]             out_radix,
  output logic [2:0]             out_suffix_kind,
  output logic                   out_overflow,
  output logic                   out_bad_octal_digit,
  output logic                   out_trailing_junk
);

  localparam int VW = VALUE_WIDTH;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;

  // token state
  phase_t          phase_r, phase_nxt;
  base_t           base_r, base_nxt;
  logic [VW-1:0]   accum_r, accum_nxt;
  logic            ovf_r, ovf_nxt;
  logic            oct_err_r, oct_err_nxt;
  logic [7:0]      sfx_buf_r [3];
  logic [7:0]      sfx_buf_nxt [3];
  logic [2:0]      sfx_cnt_r, sfx_cnt_nxt;

  // result register
  logic                   out_valid_r;
  logic [OUT_VALUE_W-1:0] out_value_r;
  logic [4:0]             out_radix_r;
  logic [2:0]             out_kind_r;
  logic                   out_ovf_r;
  logic                   out_oct_r;
  logic                   out_junk_r;

  logic advance;
  logic emit;

  // character classes
  logic       c_dig, c_hex_alpha, c_is_x, c_is_zero, c_oct_bad;
  logic [3:0] c_val;
  base_t      eff_base;
  logic       digit_mode, digit_ok, take_digit, to_suffix;

  // stage handshake
  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign emit     = advance && s1_last_r;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  // classify the registered character
  always_comb begin
    c_dig       = s1_ch_r inside {[CH_ZERO:CH_NINE]};
    c_hex_alpha = (s1_ch_r inside {[CH_LO_A:CH_LO_F]}) || (s1_ch_r inside {[CH_UP_A:CH_UP_F]});
    c_is_x      = (s1_ch_r == CH_LO_X) || (s1_ch_r == CH_UP_X);
    c_is_zero   = (s1_ch_r == CH_ZERO);
    c_oct_bad   = (s1_ch_r == CH_EIGHT) || (s1_ch_r == CH_NINE);
    if (c_dig) begin
      c_val = 4'(s1_ch_r - CH_ZERO);
    end else begin
      c_val = 4'((s1_ch_r & UPPER_MASK) - CH_UP_A + 8'd10);
    end
  end

  // next phase and base
  always_comb begin
    eff_base   = base_r;
    digit_mode = 1'b0;
    phase_nxt  = phase_r;
    case (phase_r)
      PH_START: begin
        eff_base   = c_is_zero ? BASE_OCT : BASE_DEC;
        digit_mode = !c_is_zero;
      end
      PH_ZERO: begin
        eff_base   = c_is_x ? BASE_HEX : BASE_OCT;
        digit_mode = !c_is_x;
      end
      PH_DIGITS: begin
        digit_mode = 1'b1;
      end
      default: begin
        digit_mode = 1'b0;
      end
    endcase
    digit_ok   = (eff_base == BASE_HEX) ? (c_dig || c_hex_alpha) : c_dig;
    take_digit = digit_mode && digit_ok;
    to_suffix  = (digit_mode && !digit_ok) || (phase_r == PH_SUFFIX);
    if (to_suffix) begin
      phase_nxt = PH_SUFFIX;
    end else if (take_digit || (phase_r == PH_ZERO)) begin
      phase_nxt = PH_DIGITS;
    end else if (phase_r == PH_START) begin
      phase_nxt = PH_ZERO;
    end
    base_nxt = eff_base;
  end

  // accumulator update and suffix capture
  logic [VW+3:0] dec_sum;
  logic [VW-1:0] oct_sum, hex_sum;
  logic [VW+3:0] n_ext;
  always_comb begin
    n_ext   = {4'b0, accum_r};
    dec_sum = (n_ext << 3) + (n_ext << 1) + (VW+4)'(c_val);
    oct_sum = (accum_r << 3) + VW'(c_val);
    hex_sum = (accum_r << 4) + VW'(c_val);

    accum_nxt   = accum_r;
    ovf_nxt     = ovf_r;
    oct_err_nxt = oct_err_r;
    if (take_digit) begin
      case (eff_base)
        BASE_HEX: begin
          accum_nxt = hex_sum;
          ovf_nxt   = ovf_r || (|accum_r[VW-1:VW-4]);
        end
        BASE_OCT: begin
          accum_nxt   = oct_sum;
          ovf_nxt     = ovf_r || (|accum_r[VW-1:VW-3]);
          oct_err_nxt = oct_err_r || c_oct_bad;
        end
        default: begin
          accum_nxt = dec_sum[VW-1:0];
          ovf_nxt   = ovf_r || (|dec_sum[VW+3:VW]);
        end
      endcase
    end

    sfx_buf_nxt = sfx_buf_r;
    sfx_cnt_nxt = sfx_cnt_r;
    if (to_suffix) begin
      if (sfx_cnt_r < SFX_DEPTH) begin
        sfx_buf_nxt[sfx_cnt_r[1:0]] = s1_ch_r;
      end
      if (sfx_cnt_r < SFX_SAT) begin
        sfx_cnt_nxt = sfx_cnt_r + 3'd1;
      end
    end
  end

  // greedy suffix match on the updated buffer
  logic [7:0] sa, sb, sc;
  logic [2:0] kind;
  logic [2:0] mlen;
  always_comb begin
    sa = (sfx_cnt_nxt > 3'd0) ? sfx_buf_nxt[0] : 8'd0;
    sb = (sfx_cnt_nxt > 3'd1) ? sfx_buf_nxt[1] : 8'd0;
    sc = (sfx_cnt_nxt > 3'd2) ? sfx_buf_nxt[2] : 8'd0;
    if (is_u(sa) && is_ll_pair(sb, sc)) begin
      kind = SFX_ULL;
      mlen = 3'd3;
    end else if (is_ll_pair(sa, sb) && is_u(sc)) begin
      kind = SFX_ULL;
      mlen = 3'd3;
    end else if (is_ll_pair(sa, sb)) begin
      kind = SFX_LL;
      mlen = 3'd2;
    end else if ((is_l(sa) && is_u(sb)) || (is_u(sa) && is_l(sb))) begin
      kind = SFX_UL;
      mlen = 3'd2;
    end else if (is_l(sa)) begin
      kind = SFX_L;
      mlen = 3'd1;
    end else if (is_u(sa)) begin
      kind = SFX_U;
      mlen = 3'd1;
    end else begin
      kind = SFX_NONE;
      mlen = 3'd0;
    end
  end

  // token state registers; cleared after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      phase_r      <= PH_START;
      base_r       <= BASE_DEC;
      accum_r      <= '0;
      ovf_r        <= 1'b0;
      oct_err_r    <= 1'b0;
      sfx_buf_r[0] <= 8'd0;
      sfx_buf_r[1] <= 8'd0;
      sfx_buf_r[2] <= 8'd0;
      sfx_cnt_r    <= 3'd0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      base_r    <= base_nxt;
      accum_r   <= accum_nxt;
      ovf_r     <= ovf_nxt;
      oct_err_r <= oct_err_nxt;
      sfx_buf_r <= sfx_buf_nxt;
      sfx_cnt_r <= sfx_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= OUT_VALUE_W'(accum_nxt);
      case (base_nxt)
        BASE_HEX: out_radix_r <= RADIX_HEX;
        BASE_OCT: out_radix_r <= RADIX_OCT;
        default:  out_radix_r <= RADIX_DEC;
      endcase
      out_kind_r <= kind;
      out_ovf_r  <= ovf_nxt;
      out_oct_r  <= (base_nxt == BASE_OCT) && oct_err_nxt;
      out_junk_r <= sfx_cnt_nxt > mlen;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_value           = out_value_r;
  assign out_radix           = out_radix_r;
  assign out_suffix_kind     = out_kind_r;
  assign out_overflow        = out_ovf_r;
  assign out_bad_octal_digit = out_oct_r;
  assign out_trailing_junk   = out_junk_r;

endmodule

// File: bench/integer_literal_checker.sv
`timescale 1ns / 1ps

module integer_literal_checker
  import ilp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_ch,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [OUT_VALUE_W-1:0] out_value,
  input  logic [4:0]             out_radix,
  input  logic [2:0]             out_suffix_kind,
  input  logic                   out_overflow,
  input  logic                   out_bad_octal_digit,
  input  logic                   out_trailing_junk,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);

  localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  radix;
    logic [2:0]  kind;
    logic        ovf;
    logic        bad_oct;
    logic        junk;
  } literal_t;

  literal_t    literal_q[$];
  literal_t    want;

  // token state of the predictor
  logic [63:0] acc;
  phase_t      scan_phase;
  base_t       scan_base;
  logic        ovf_seen;
  logic        octal_bad;
  logic [7:0]  tail_buf [3];
  logic [2:0]  tail_count;
  int          errs;
  int          checked;

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic hex_letter(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic u_char(input logic [7:0] c);
    return (c == CH_LO_U) || (c == CH_UP_U);
  endfunction

  function automatic logic l_char(input logic [7:0] c);
    return (c == CH_LO_L) || (c == CH_UP_L);
  endfunction

  // long-long needs both letters in the same case
  function automatic logic same_case_ll(input logic [7:0] a, input logic [7:0] b);
    return ((a == CH_LO_L) && (b == CH_LO_L)) || ((a == CH_UP_L) && (b == CH_UP_L));
  endfunction

  function automatic logic [7:0] tail_at(input int i);
    return ((i < tail_count) && (i < 3)) ? tail_buf[i] : 8'h00;
  endfunction

  task automatic clear_token();
    acc        = '0;
    scan_phase = PH_START;
    scan_base  = BASE_DEC;
    ovf_seen   = 1'b0;
    octal_bad  = 1'b0;
    tail_count = '0;
    for (int i = 0; i < 3; i++) tail_buf[i] = 8'h00;
  endtask

  // only three tail characters are kept, the count saturates one above that
  task automatic push_tail(input logic [7:0] c);
    if (tail_count < SFX_DEPTH) tail_buf[tail_count[1:0]] = c;
    if (tail_count < SFX_SAT) tail_count = tail_count + 3'd1;
  endtask

  // shift-add one digit, or end the digits on anything else
  task automatic add_digit(input logic [7:0] c);
    logic [63:0] n;
    logic [63:0] d;
    n = acc & WIDTH_MASK;
    if (!dec_char(c) && !((scan_base == BASE_HEX) && hex_letter(c))) begin
      scan_phase = PH_SUFFIX;
      push_tail(c);
    end else if (scan_base == BASE_HEX) begin
      d = dec_char(c) ? 64'(c - CH_ZERO) : 64'(8'((c & UPPER_MASK) - CH_UP_A + 8'd10));
      if ((n & ~(WIDTH_MASK >> 4)) != 0) ovf_seen = 1'b1;
      acc = ((n << 4) + d) & WIDTH_MASK;
    end else if (scan_base == BASE_OCT) begin
      d = 64'(c - CH_ZERO);
      if ((c == CH_EIGHT) || (c == CH_NINE)) octal_bad = 1'b1;
      if ((n & ~(WIDTH_MASK >> 3)) != 0) ovf_seen = 1'b1;
      acc = ((n << 3) + d) & WIDTH_MASK;
    end else begin
      d = 64'(c - CH_ZERO);
      if (n > (WIDTH_MASK - d) / 64'd10) ovf_seen = 1'b1;
      acc = (n * 64'd10 + d) & WIDTH_MASK;
    end
  endtask

  // advance the token by one character; on the last one queue the literal
  task automatic scan_char(input logic [7:0] c, input logic is_last);
    literal_t   lit;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] e;
    int         len;
    case (scan_phase)
      PH_ZERO: begin
        scan_phase = PH_DIGITS;
        if ((c == CH_LO_X) || (c == CH_UP_X)) begin
          scan_base = BASE_HEX;
        end else begin
          add_digit(c);
        end
      end
      PH_DIGITS: add_digit(c);
      PH_SUFFIX: push_tail(c);
      default: begin
        if (c == CH_ZERO) begin
          scan_base  = BASE_OCT;
          scan_phase = PH_ZERO;
        end else begin
          scan_base  = BASE_DEC;
          scan_phase = PH_DIGITS;
          add_digit(c);
        end
      end
    endcase
    if (is_last) begin
      a = tail_at(0);
      b = tail_at(1);
      e = tail_at(2);
      // greedy suffix match, longest forms first
      if (u_char(a) && same_case_ll(b, e)) begin
        lit.kind = SFX_ULL; len = 3;
      end else if (same_case_ll(a, b) && u_char(e)) begin
        lit.kind = SFX_ULL; len = 3;
      end else if (same_case_ll(a, b)) begin
        lit.kind = SFX_LL; len = 2;
      end else if ((l_char(a) && u_char(b)) || (u_char(a) && l_char(b))) begin
        lit.kind = SFX_UL; len = 2;
      end else if (l_char(a)) begin
        lit.kind = SFX_L; len = 1;
      end else if (u_char(a)) begin
        lit.kind = SFX_U; len = 1;
      end else begin
        lit.kind = SFX_NONE; len = 0;
      end
      lit.value   = acc & WIDTH_MASK;
      lit.radix   = (scan_base == BASE_HEX) ? RADIX_HEX :
                    (scan_base == BASE_OCT) ? RADIX_OCT : RADIX_DEC;
      lit.ovf     = ovf_seen;
      lit.bad_oct = (scan_base == BASE_OCT) ? octal_bad : 1'b0;
      lit.junk    = (int'(tail_count) > len);
      literal_q.push_back(lit);
      clear_token();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      errs++;
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_token();
      literal_q.delete();
      errs    = 0;
      checked = 0;
    end else begin
      if (in_valid && !in_stall) scan_char(in_ch, in_last);
      if (out_valid && !out_stall) begin
        if (literal_q.size() == 0) begin
          $error("result item with no literal pending: value %0h", out_value);
          errs++;
        end else begin
          want = literal_q.pop_front();
          checked++;
          check_field("value", want.value, 64'(out_value));
          check_field("radix", 64'(want.radix), 64'(out_radix));
          check_field("suffix_kind", 64'(want.kind), 64'(out_suffix_kind));
          check_field("overflow", 64'(want.ovf), 64'(out_overflow));
          check_field("bad_octal_digit", 64'(want.bad_oct), 64'(out_bad_octal_digit));
          check_field("trailing_junk", 64'(want.junk), 64'(out_trailing_junk));
        end
      end
    end
    fail_count    <= errs;
    pending_count <= literal_q.size();
    result_count  <= checked;
  end

endmodule

// File: bench/tb_integer_literal_parser_unit.sv
`timescale 1ns / 1ps

module tb_integer_literal_parser_unit;
  import ilp_pkg::*;

  localparam int CHAR_TARGET = 850;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [7:0] char_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_ch;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OUT_VALUE_W-1:0] out_value;
  logic [4:0]             out_radix;
  logic [2:0]             out_suffix_kind;
  logic                   out_overflow;
  logic                   out_bad_octal_digit;
  logic                   out_trailing_junk;

  int fail_count;
  int pending_count;
  int result_count;
  int cycle_count = 0;
  int in_idle_pct = 22;
  int out_idle_pct = 71;
  int chars_sent = 0;
  int tokens_sent = 0;
  int noise_tokens = 0;

  always #6 clk = ~clk;

  integer_literal_parser_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value           (out_value),
    .out_radix           (out_radix),
    .out_suffix_kind     (out_suffix_kind),
    .out_overflow        (out_overflow),
    .out_bad_octal_digit (out_bad_octal_digit),
    .out_trailing_junk   (out_trailing_junk)
  );

  integer_literal_checker literal_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value           (out_value),
    .out_radix           (out_radix),
    .out_suffix_kind     (out_suffix_kind),
    .out_overflow        (out_overflow),
    .out_bad_octal_digit (out_bad_octal_digit),
    .out_trailing_junk   (out_trailing_junk),
    .fail_count          (fail_count),
    .pending_count       (pending_count),
    .result_count        (result_count)
  );

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one character item, with random gaps before it
  task automatic send_char(input logic [7:0] c, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_token(input char_q_t tok);
    for (int i = 0; i < tok.size(); i++) send_char(tok[i], i == tok.size() - 1);
    tokens_sent++;
  endtask

  function automatic char_q_t text_chars(input string s);
    char_q_t tok;
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    return tok;
  endfunction

  // hold off the sender until every literal has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] u_letter();
    return $urandom_range(1) ? CH_UP_U : CH_LO_U;
  endfunction

  function automatic logic [7:0] l_letter();
    return $urandom_range(1) ? CH_UP_L : CH_LO_L;
  endfunction

  function automatic logic [7:0] hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + v - 10);
  endfunction

  // optional prefix, digits, a suffix form with random case, sometimes junk after it
  function automatic char_q_t literal_token();
    char_q_t    tok;
    int         ndig;
    int         form;
    logic [7:0] lc;
    // mostly short, now and then long enough to overflow
    ndig = ($urandom_range(9) == 0) ? $urandom_range(16, 26) : $urandom_range(1, 8);
    case ($urandom_range(2))
      0: begin
        tok.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
        repeat (ndig - 1) tok.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      1: begin
        tok.push_back(CH_ZERO);
        repeat (ndig - 1)
          tok.push_back(($urandom_range(9) == 0) ? 8'(CH_EIGHT + $urandom_range(1)) :
                                                    8'(CH_ZERO + $urandom_range(7)));
      end
      default: begin
        tok.push_back(CH_ZERO);
        tok.push_back($urandom_range(1) ? CH_UP_X : CH_LO_X);
        repeat (ndig - 1) tok.push_back(hex_digit());
      end
    endcase
    form = $urandom_range(8);
    lc = l_letter();
    // u before the l's
    if ((form == 1) || (form == 3) || (form == 6)) tok.push_back(u_letter());
    if ((form == 2) || (form == 3) || (form == 4)) tok.push_back(lc);
    if ((form == 5) || (form == 6) || (form == 7)) begin
      tok.push_back(lc);
      tok.push_back(($urandom_range(4) == 0) ? l_letter() : lc);
    end
    // u after the l's
    if ((form == 4) || (form == 7)) tok.push_back(u_letter());
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(1, 3)) tok.push_back(8'($urandom_range(255)));
    return tok;
  endfunction

  function automatic char_q_t noise_token();
    char_q_t tok;
    repeat ($urandom_range(1, 5)) tok.push_back(8'($urandom_range(255)));
    return tok;
  endfunction

  initial begin
    char_q_t tok;
    int      stage;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_ch    = 8'h00;
    in_last  = 1'b0;
    stage    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed tokens: prefixes, bad octal digit, suffix forms, mixed-case ll,
    // non-digit start, zero and all-ones characters, junk after the suffix
    send_token(text_chars("0"));
    send_token(text_chars("0x"));
    send_token(text_chars("09u"));
    send_token(text_chars("7LL"));
    send_token(text_chars("1lL"));
    tok = {8'h00};
    send_token(tok);
    tok = {8'h35, 8'hff};
    send_token(tok);
    send_token(text_chars("0XfFz"));
    send_token(text_chars("u"));
    send_token(text_chars("42lu"));

    // random tokens over three idling patterns
    while (chars_sent < CHAR_TARGET) begin
      if ((stage == 0) && (chars_sent >= CHAR_TARGET / 3)) begin
        stage = 1;
        drain();
        in_idle_pct  = 71;
        out_idle_pct = 22;
      end else if ((stage == 1) && (chars_sent >= 2 * CHAR_TARGET / 3)) begin
        stage = 2;
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if ($urandom_range(4) == 0) begin
        send_token(noise_token());
        noise_tokens++;
      end else begin
        send_token(literal_token());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d characters in %0d tokens (%0d random-byte), %0d literals checked",
             chars_sent, tokens_sent, noise_tokens, result_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ilp_pkg.sv
hdl/integer_literal_parser_unit.sv
bench/integer_literal_checker.sv
bench/tb_integer_literal_parser_unit.sv
